/* rtl/core/arte_pkg.sv */
// Shared types and constants for the record table with eviction.
// Used by the controller, the datapath, the top level and the checker.
package arte_pkg;

  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_STOP   = 3'd1;
  localparam logic [2:0] KIND_RENAME = 3'd2;
  localparam logic [2:0] KIND_TOUCH  = 3'd3;
  localparam logic [2:0] KIND_VIEW   = 3'd4;
  localparam logic [2:0] KIND_FIND   = 3'd5;
  localparam logic [2:0] KIND_SNAP   = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] VIEW_NONE = 2'd0;
  localparam logic [1:0] VIEW_BACK = 2'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] app_key;
    logic [63:0] new_key;
    logic [2:0]  app_type;
    logic [47:0] now_time;
    logic [1:0]  view_mode;
    logic [4:0]  max_count;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] record_id;
    logic [63:0] record_key;
    logic        run_state;
    logic [2:0]  record_type;
    logic [1:0]  record_view;
    logic [47:0] active_time;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_WRITE,
    S_SNAP
  } state_e;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       pick;
    logic       write;
    logic       snap;
    logic       empty;
    logic [1:0] empty_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_end;
    logic       pick_ok;
    logic [1:0] pick_status;
    logic       snap_end;
  } dp_stat_t;

endpackage

/* rtl/core/arte_ctrl.sv */
// Sequencing state machine for the record table.
// Depends on arte_pkg for the state, command and status types.
module arte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [2:0]          kind_i,
  input  arte_pkg::dp_stat_t  stat_i,
  output arte_pkg::dp_cmd_t   cmd_o,
  output logic                busy
);

  arte_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != arte_pkg::S_IDLE);
    unique case (state_q)
      arte_pkg::S_IDLE: begin
        if (start) begin
          if (kind_i == arte_pkg::KIND_SNAP) begin
            cmd_o.load = 1'b1;
            state_d    = arte_pkg::S_SNAP;
          end else if (kind_i > arte_pkg::KIND_SNAP) begin
            // An undefined operation answers at once and changes nothing.
            cmd_o.empty        = 1'b1;
            cmd_o.empty_status = arte_pkg::ST_NONE;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = arte_pkg::S_SCAN;
          end
        end
      end
      arte_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_end) begin
          state_d = arte_pkg::S_PICK;
        end
      end
      arte_pkg::S_PICK: begin
        if (stat_i.pick_ok) begin
          cmd_o.pick = 1'b1;
          state_d    = arte_pkg::S_WRITE;
        end else begin
          cmd_o.empty        = 1'b1;
          cmd_o.empty_status = stat_i.pick_status;
          state_d            = arte_pkg::S_IDLE;
        end
      end
      arte_pkg::S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = arte_pkg::S_IDLE;
      end
      arte_pkg::S_SNAP: begin
        cmd_o.snap = 1'b1;
        if (stat_i.snap_end) begin
          state_d = arte_pkg::S_IDLE;
        end
      end
      default: state_d = arte_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/core/arte_dp.sv */
// Datapath of the record table: entry memory, used bits, scan registers and result register.
// Depends on arte_pkg; driven by arte_ctrl through command and status structs.
module arte_dp #(
  parameter int TABLE_DEPTH = 24,
  parameter int KEY_BITS    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arte_pkg::item_t     item_i,
  input  arte_pkg::dp_cmd_t   cmd_i,
  output arte_pkg::dp_stat_t  stat_o,
  output logic                res_valid_o,
  output arte_pkg::result_t   res_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         id;
    logic                running;
    logic [2:0]          rtype;
    logic [1:0]          view;
    logic [47:0]         time_ms;
  } entry_t;

  entry_t               mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] used_q, used_d;

  arte_pkg::item_t in_q;
  logic [AW-1:0] ptr_q, rptr_q, tgt_q;
  logic          run_q, rvalid_q, rused_q;
  entry_t        rd_q;
  logic          fa_q, fb_q, ff_q, fv_q, new_q;
  logic [AW-1:0] ia_q, ib_q, if_q, iv_q;
  logic [47:0]   vt_q;
  logic [4:0]    cnt_q;
  logic [31:0]   nid_q;

  logic          issue, rd_en;
  logic [AW-1:0] rd_addr, tgt;
  logic          eval, hit_a, hit_b;
  logic [KEY_BITS-1:0] key_a, key_b;
  entry_t        ne;
  logic          emit_now, last_now, snap_empty, above;
  logic [TABLE_DEPTH-1:0] used_shift;
  arte_pkg::result_t res_d;
  logic          valid_d;

  function automatic arte_pkg::result_t to_res(entry_t e, logic last);
    arte_pkg::result_t r;
    r.status      = arte_pkg::ST_OK;
    r.record_id   = e.id;
    r.record_key  = 64'(e.key);
    r.run_state   = e.running;
    r.record_type = e.rtype;
    r.record_view = e.view;
    r.active_time = e.time_ms;
    r.last        = last;
    return r;
  endfunction

  assign key_a   = in_q.app_key[KEY_BITS-1:0];
  assign key_b   = in_q.new_key[KEY_BITS-1:0];
  assign issue   = (cmd_i.scan || cmd_i.snap) && run_q;
  assign rd_en   = issue || cmd_i.pick;
  assign rd_addr = cmd_i.pick ? tgt : ptr_q;
  assign eval    = cmd_i.scan && rvalid_q;
  assign hit_a   = rused_q && (rd_q.key == key_a);
  assign hit_b   = rused_q && (rd_q.key == key_b);

  always_comb begin
    stat_o.scan_end    = rvalid_q && (rptr_q == LAST_IDX);
    stat_o.pick_ok     = 1'b1;
    stat_o.pick_status = arte_pkg::ST_OK;
    tgt                = ia_q;
    if (!fa_q) begin
      if (in_q.kind == arte_pkg::KIND_START) begin
        if (ff_q) begin
          tgt = if_q;
        end else if (fv_q) begin
          tgt = iv_q;
        end else begin
          stat_o.pick_ok     = 1'b0;
          stat_o.pick_status = arte_pkg::ST_FULL;
        end
      end else begin
        stat_o.pick_ok     = 1'b0;
        stat_o.pick_status = arte_pkg::ST_NONE;
      end
    end
    stat_o.snap_end = (cnt_q == in_q.max_count) ||
                      (rvalid_q && (rptr_q == LAST_IDX));
  end

  // Snapshot emission: the last flag comes from the count limit or from no used entry above.
  assign used_shift = (used_q >> rptr_q) >> 1;
  assign above      = |used_shift;
  assign emit_now   = cmd_i.snap && rvalid_q && rused_q && (cnt_q < in_q.max_count);
  assign last_now   = ((cnt_q + 5'd1) == in_q.max_count) || !above;
  assign snap_empty = cmd_i.snap && stat_o.snap_end && (cnt_q == 5'd0) && !emit_now;

  always_comb begin
    ne = rd_q;
    case (in_q.kind)
      arte_pkg::KIND_START: begin
        if (new_q) begin
          ne.key = key_a;
          ne.id  = nid_q;
        end
        ne.running = 1'b1;
        ne.rtype   = in_q.app_type;
        ne.view    = arte_pkg::VIEW_BACK;
        ne.time_ms = in_q.now_time;
      end
      arte_pkg::KIND_STOP: begin
        ne.running = 1'b0;
        ne.view    = arte_pkg::VIEW_NONE;
      end
      arte_pkg::KIND_RENAME: ne.key = key_b;
      arte_pkg::KIND_TOUCH:  ne.time_ms = in_q.now_time;
      arte_pkg::KIND_VIEW: begin
        if (rd_q.running) begin
          ne.view = in_q.view_mode;
        end
      end
      default: ne = rd_q;
    endcase
  end

  always_comb begin
    used_d = used_q;
    if (cmd_i.write) begin
      if (in_q.kind == arte_pkg::KIND_RENAME && fb_q && (ib_q != tgt_q)) begin
        used_d[ib_q] = 1'b0;
      end
      used_d[tgt_q] = 1'b1;
    end
  end

  always_comb begin
    res_d   = '0;
    valid_d = 1'b0;
    if (cmd_i.empty || snap_empty) begin
      valid_d      = 1'b1;
      res_d.status = cmd_i.empty ? cmd_i.empty_status : arte_pkg::ST_NONE;
      res_d.last   = 1'b1;
    end else if (cmd_i.write) begin
      valid_d = 1'b1;
      res_d   = to_res(ne, 1'b1);
    end else if (emit_now) begin
      valid_d = 1'b1;
      res_d   = to_res(rd_q, last_now);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[tgt_q] <= ne;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
    if (cmd_i.load) begin
      in_q <= item_i;
    end
    if (issue) begin
      rptr_q  <= ptr_q;
      rused_q <= used_q[ptr_q];
    end
    if (cmd_i.pick) begin
      tgt_q <= tgt;
      new_q <= (in_q.kind == arte_pkg::KIND_START) && !fa_q;
    end
    if (eval && hit_a && !fa_q) begin
      ia_q <= rptr_q;
    end
    if (eval && hit_b && !fb_q) begin
      ib_q <= rptr_q;
    end
    if (eval && !rused_q && !ff_q) begin
      if_q <= rptr_q;
    end
    if (eval && rused_q && !rd_q.running && (!fv_q || rd_q.time_ms < vt_q)) begin
      iv_q <= rptr_q;
      vt_q <= rd_q.time_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      res_valid_o <= 1'b0;
      nid_q       <= 32'd1;
      run_q       <= 1'b0;
      rvalid_q    <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      fa_q        <= 1'b0;
      fb_q        <= 1'b0;
      ff_q        <= 1'b0;
      fv_q        <= 1'b0;
    end else begin
      used_q      <= used_d;
      res_valid_o <= valid_d;
      if (cmd_i.write && new_q) begin
        nid_q <= nid_q + 32'd1;
      end
      if (cmd_i.load) begin
        run_q    <= 1'b1;
        rvalid_q <= 1'b0;
        ptr_q    <= '0;
        cnt_q    <= '0;
        fa_q     <= 1'b0;
        fb_q     <= 1'b0;
        ff_q     <= 1'b0;
        fv_q     <= 1'b0;
      end else begin
        rvalid_q <= issue;
        if (issue) begin
          if (ptr_q == LAST_IDX) begin
            run_q <= 1'b0;
          end else begin
            ptr_q <= ptr_q + AW'(1);
          end
        end
        if (emit_now) begin
          cnt_q <= cnt_q + 5'd1;
        end
        if (eval && hit_a) begin
          fa_q <= 1'b1;
        end
        if (eval && hit_b) begin
          fb_q <= 1'b1;
        end
        if (eval && !rused_q) begin
          ff_q <= 1'b1;
        end
        if (eval && rused_q && !rd_q.running) begin
          fv_q <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/app_record_table_with_eviction.sv */
// Top level of the application record table with eviction.
// Depends on arte_pkg, arte_ctrl and arte_dp.
//
//   Channel   Handshake                 Word
//   command   start in, busy out        item_i   (arte_pkg::item_t)
//   result    res_valid_o strobe out    res_o    (arte_pkg::result_t)
//
// A lookup operation reads the table one entry per cycle through the entry memory's
// single registered read port, then picks, rereads and writes the chosen entry. A
// snapshot streams one result per used entry, up to max_count, in the same pass. An
// undefined operation code answers in the next cycle without raising busy. Reset
// clears the used bits and sets the id counter to one; the table is usable at once.
// Results are shown for one cycle each and cannot be held off; once raised, busy
// stays high until the final result is registered.
module app_record_table_with_eviction #(
  parameter int TABLE_DEPTH = 24,
  parameter int KEY_BITS    = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  arte_pkg::item_t   item_i,
  output logic              res_valid_o,
  output arte_pkg::result_t res_o
);

  arte_pkg::dp_cmd_t  cmd;
  arte_pkg::dp_stat_t stat;

  arte_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (item_i.kind),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  arte_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

/* rtl/core/arte_checker.sv */
// Port-level checks for the record table and the bind that attaches them.
// Depends on arte_pkg and the top level's ports.
module arte_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input arte_pkg::result_t res_o
);

  a_accept_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o)
    else $error("accepted word neither started work nor answered");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !res_valid_o)
    else $error("result appeared with no work pending");

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != arte_pkg::ST_OK) |-> res_o.last)
    else $error("failure result not marked last");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != arte_pkg::ST_OK) |->
      (res_o.record_id == 32'd0) && (res_o.active_time == 48'd0))
    else $error("failure result carries record data");

endmodule

bind app_record_table_with_eviction arte_checker u_arte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

/* tb/testbench.sv */
// Self-checking testbench for the application record table with eviction.
// Depends on arte_pkg and the top level app_record_table_with_eviction.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import arte_pkg::*;

  localparam int DEPTH = 24;
  localparam int WATCHDOG_LIMIT = 20000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    res_valid_o;
  result_t res_o;

  app_record_table_with_eviction dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the record table, updated as each command word is accepted.
  logic        tbl_used [DEPTH];
  logic [63:0] tbl_key  [DEPTH];
  logic [31:0] tbl_id   [DEPTH];
  logic        tbl_run  [DEPTH];
  logic [2:0]  tbl_type [DEPTH];
  logic [1:0]  tbl_view [DEPTH];
  logic [47:0] tbl_time [DEPTH];
  logic [31:0] id_counter;

  item_t   pending_cmds[$];
  result_t expected_results[$];
  int      errors = 0;
  int      sent = 0;
  int      quiet_cycles = 0;
  bit      hold_sender = 1'b0;
  bit      no_idle = 1'b0;

  function automatic int find_record(logic [63:0] k);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_used[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic result_t record_word(int i, logic lst);
    result_t r;
    r.status = ST_OK;
    r.record_id = tbl_id[i];
    r.record_key = tbl_key[i];
    r.run_state = tbl_run[i];
    r.record_type = tbl_type[i];
    r.record_view = tbl_view[i];
    r.active_time = tbl_time[i];
    r.last = lst;
    return r;
  endfunction

  function automatic result_t empty_word(logic [1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Applies one command to the shadow table and queues the words it should produce.
  function automatic void apply_command(item_t c);
    int i, d, n, victim;
    if (c.kind == KIND_SNAP) begin
      n = 0;
      for (i = 0; i < DEPTH && n < c.max_count; i++)
        if (tbl_used[i]) begin
          expected_results.push_back(record_word(i, 1'b0));
          n++;
        end
      if (n == 0) expected_results.push_back(empty_word(ST_NONE));
      else expected_results[$].last = 1'b1;
      return;
    end
    if (c.kind == 3'd7) begin
      expected_results.push_back(empty_word(ST_NONE));
      return;
    end
    i = find_record(c.app_key);
    if (c.kind == KIND_START) begin
      if (i < 0) begin
        victim = -1;
        for (int j = 0; j < DEPTH; j++) begin
          if (!tbl_used[j]) begin
            victim = j;
            break;
          end
          if (!tbl_run[j] && (victim < 0 || tbl_time[j] < tbl_time[victim])) victim = j;
        end
        if (victim < 0) begin
          expected_results.push_back(empty_word(ST_FULL));
          return;
        end
        i = victim;
        tbl_used[i] = 1'b1;
        tbl_key[i] = c.app_key;
        tbl_id[i] = id_counter;
        id_counter = id_counter + 32'd1;
      end
      tbl_run[i] = 1'b1;
      tbl_type[i] = c.app_type;
      tbl_view[i] = VIEW_BACK;
      tbl_time[i] = c.now_time;
    end else if (i < 0) begin
      expected_results.push_back(empty_word(ST_NONE));
      return;
    end else begin
      case (c.kind)
        KIND_STOP: begin
          tbl_run[i] = 1'b0;
          tbl_view[i] = VIEW_NONE;
        end
        KIND_RENAME: begin
          d = find_record(c.new_key);
          if (d >= 0 && d != i) tbl_used[d] = 1'b0;
          tbl_key[i] = c.new_key;
        end
        KIND_TOUCH: tbl_time[i] = c.now_time;
        KIND_VIEW: if (tbl_run[i]) tbl_view[i] = c.view_mode;
        default: ;
      endcase
    end
    expected_results.push_back(record_word(i, 1'b1));
  endfunction

  // Driver: a word is taken at an edge where start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_command(item_i);
        sent <= sent + 1;
      end
      if (start && busy) begin
        // Word not yet taken; keep it on the port.
      end else if (pending_cmds.size() > 0 && !hold_sender &&
                   (no_idle || $urandom_range(99) >= 25)) begin
        item_i <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: %p", res_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_o.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, res_o.status); errors++;
        end
        if (res_o.record_id !== e.record_id) begin
          $error("record_id: expected %0h actual %0h", e.record_id, res_o.record_id);
          errors++;
        end
        if (res_o.record_key !== e.record_key) begin
          $error("record_key: expected %0h actual %0h", e.record_key, res_o.record_key);
          errors++;
        end
        if (res_o.run_state !== e.run_state) begin
          $error("run_state: expected %0d actual %0d", e.run_state, res_o.run_state);
          errors++;
        end
        if (res_o.record_type !== e.record_type) begin
          $error("record_type: expected %0d actual %0d", e.record_type, res_o.record_type);
          errors++;
        end
        if (res_o.record_view !== e.record_view) begin
          $error("record_view: expected %0d actual %0d", e.record_view, res_o.record_view);
          errors++;
        end
        if (res_o.active_time !== e.active_time) begin
          $error("active_time: expected %0h actual %0h", e.active_time, res_o.active_time);
          errors++;
        end
        if (res_o.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, res_o.last); errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result word moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Keys come from a small pool so that lookups hit often; a few are fully random.
  logic [63:0] key_pool[8];

  function automatic logic [63:0] pick_key();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(7)];
  endfunction

  function automatic item_t make_cmd(logic [2:0] k, logic [63:0] a, logic [63:0] b);
    item_t c;
    c.kind = k;
    c.app_key = a;
    c.new_key = b;
    c.app_type = 3'($urandom);
    c.now_time = {16'($urandom), $urandom};
    c.view_mode = 2'($urandom);
    c.max_count = 5'($urandom_range(24));
    return c;
  endfunction

  initial begin
    item_t c;
    for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
    id_counter = 32'd1;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};

    // Directed part: empty table, extremes, every operation, the special cases.
    pending_cmds.push_back(make_cmd(KIND_SNAP, '0, '0));           // nothing to report
    pending_cmds.push_back(make_cmd(KIND_FIND, '1, '0));           // not found
    c = make_cmd(KIND_START, '0, '0); c.app_type = 3'd7; c.now_time = '1;
    pending_cmds.push_back(c);
    c = make_cmd(KIND_START, '1, '0); c.app_type = 3'd0; c.now_time = '0;
    pending_cmds.push_back(c);
    c = make_cmd(KIND_VIEW, '1, '0); c.view_mode = 2'd3;            // view code 3
    pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(KIND_STOP, '1, '0));
    c = make_cmd(KIND_VIEW, '1, '0); c.view_mode = 2'd2;            // view kept while stopped
    pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(KIND_TOUCH, '0, '0));
    pending_cmds.push_back(make_cmd(KIND_RENAME, '0, '0));          // rename to own name
    pending_cmds.push_back(make_cmd(KIND_RENAME, '0, '1));          // frees the duplicate
    pending_cmds.push_back(make_cmd(KIND_FIND, '1, '0));
    c = make_cmd(KIND_SNAP, '0, '0); c.max_count = 5'd0;
    pending_cmds.push_back(c);
    c = make_cmd(3'd7, '0, '0);
    pending_cmds.push_back(c);
    // Fill the table with running records, then one more start finds it full.
    for (int i = 0; i < DEPTH; i++)
      pending_cmds.push_back(make_cmd(KIND_START, 64'(i + 100), '0));
    pending_cmds.push_back(make_cmd(KIND_START, 64'd5000, '0));
    c = make_cmd(KIND_SNAP, '0, '0); c.max_count = 5'd31;
    pending_cmds.push_back(c);
    // Two stopped records with equal times: the lower index is evicted.
    c = make_cmd(KIND_TOUCH, 64'd110, '0); c.now_time = 48'd7; pending_cmds.push_back(c);
    c = make_cmd(KIND_TOUCH, 64'd105, '0); c.now_time = 48'd7; pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(KIND_STOP, 64'd110, '0));
    pending_cmds.push_back(make_cmd(KIND_STOP, 64'd105, '0));
    pending_cmds.push_back(make_cmd(KIND_START, 64'd6000, '0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !start);
    // Let the table drain completely before the random part.
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !busy);
    @(posedge clk_i);
    hold_sender = 1'b0;

    for (int n = 0; n < 116; n++) begin
      int r;
      r = $urandom_range(99);
      if (r < 30) c = make_cmd(KIND_START, pick_key(), '0);
      else if (r < 45) c = make_cmd(KIND_STOP, pick_key(), '0);
      else if (r < 55) c = make_cmd(KIND_RENAME, pick_key(), pick_key());
      else if (r < 65) c = make_cmd(KIND_TOUCH, pick_key(), '0);
      else if (r < 77) c = make_cmd(KIND_VIEW, pick_key(), '0);
      else if (r < 87) c = make_cmd(KIND_FIND, pick_key(), '0);
      else if (r < 97) c = make_cmd(KIND_SNAP, pick_key(), pick_key());
      else c = make_cmd(3'd7, pick_key(), pick_key());
      if ($urandom_range(3) == 0) c.now_time = 48'($urandom_range(3));
      pending_cmds.push_back(c);
    end
    // A stretch of back-to-back traffic in the middle of the random part.
    wait (pending_cmds.size() < 100);
    no_idle = 1'b1;
    wait (pending_cmds.size() < 60);
    no_idle = 1'b0;

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (DEPTH + 10) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
